/* hdl/perspective_divide_viewport_map_macros.svh */
// assertion helpers, clocked on clk; the implication helper is quiet while rst_n is low
`ifndef PERSPECTIVE_DIVIDE_VIEWPORT_MAP_MACROS_SVH
`define PERSPECTIVE_DIVIDE_VIEWPORT_MAP_MACROS_SVH

// same-cycle implication outside reset
`define PDVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition that must hold in the cycle after a reset edge
`define PDVM_ASSERT_AFTER_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pdvm_pkg.sv */
package pdvm_pkg;

  localparam int COORD_W = 32;
  localparam int SIZE_W  = 15;
  localparam int NUM_W   = 33;  // x + w and w - y
  localparam int PROD_W  = 48;  // (x + w) * (size - 1)
  localparam int WABS_W  = 32;  // |w|
  localparam int MAG_W   = 49;  // 2|n| + 2|w|
  localparam int DEN_W   = 34;  // 4|w|

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 15'd640;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 15'd480;

  localparam int USER_SAT = 0;
  localparam int USER_WZ  = 1;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic w_zero;
    logic last;
  } tag_t;

  typedef struct packed {
    logic [MAG_W-1:0] rem_x;
    logic [MAG_W-1:0] rem_y;
    logic [DEN_W-1:0] den;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    tag_t             tag;
  } div_item_t;

endpackage

/* hdl/pdvm_front.sv */
module pdvm_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wen,
  input  logic                           cfg_index,
  input  logic [pdvm_pkg::SIZE_W-1:0]    cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pdvm_pkg::COORD_W-1:0]   in_x,
  input  logic [pdvm_pkg::COORD_W-1:0]   in_y,
  input  logic [pdvm_pkg::COORD_W-1:0]   in_w,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_ready,
  output pdvm_pkg::div_item_t            out_item
);

  logic [pdvm_pkg::SIZE_W-1:0] width_r, height_r;
  logic [pdvm_pkg::SIZE_W-1:0] scale_x, scale_y;

  // stage 1: offsets and |w|
  logic                               s1_v_r;
  logic signed [pdvm_pkg::NUM_W-1:0]  s1_num_x_r, s1_num_y_r;
  logic [pdvm_pkg::WABS_W-1:0]        s1_wabs_r;
  logic                               s1_negw_r;
  pdvm_pkg::tag_t                     s1_tag_r;
  logic signed [pdvm_pkg::NUM_W-1:0]  num_x_nxt, num_y_nxt;
  logic [pdvm_pkg::WABS_W-1:0]        wabs_nxt;

  // stage 2: scale products
  logic                               s2_v_r;
  logic signed [pdvm_pkg::PROD_W-1:0] s2_prod_x_r, s2_prod_y_r;
  logic [pdvm_pkg::WABS_W-1:0]        s2_wabs_r;
  logic                               s2_negw_r;
  pdvm_pkg::tag_t                     s2_tag_r;
  logic signed [pdvm_pkg::PROD_W:0]   prod_x_full, prod_y_full;

  // stage 3: magnitudes and rounding offset
  logic                               s3_v_r;
  pdvm_pkg::div_item_t                s3_item_r;
  pdvm_pkg::div_item_t                item_nxt;
  logic [pdvm_pkg::PROD_W-1:0]        an_x, an_y;

  logic s1_rdy, s2_rdy, s3_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= pdvm_pkg::WIDTH_RST;
      height_r <= pdvm_pkg::HEIGHT_RST;
    end else if (cfg_wen) begin
      unique case (pdvm_pkg::cfg_reg_t'(cfg_index))
        pdvm_pkg::CFG_WIDTH:  width_r  <= cfg_wdata;
        pdvm_pkg::CFG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a size of zero acts as one
  assign scale_x = (width_r == '0) ? '0 : width_r - 1'b1;
  assign scale_y = (height_r == '0) ? '0 : height_r - 1'b1;

  assign s3_rdy   = !s3_v_r || out_ready;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  assign num_x_nxt = $signed({in_x[pdvm_pkg::COORD_W-1], in_x})
                   + $signed({in_w[pdvm_pkg::COORD_W-1], in_w});
  assign num_y_nxt = $signed({in_w[pdvm_pkg::COORD_W-1], in_w})
                   - $signed({in_y[pdvm_pkg::COORD_W-1], in_y});
  assign wabs_nxt  = in_w[pdvm_pkg::COORD_W-1] ? (~in_w + 1'b1) : in_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_num_x_r      <= num_x_nxt;
      s1_num_y_r      <= num_y_nxt;
      s1_wabs_r       <= wabs_nxt;
      s1_negw_r       <= in_w[pdvm_pkg::COORD_W-1];
      s1_tag_r.w_zero <= (in_w == '0);
      s1_tag_r.last   <= in_last;
    end
  end

  assign prod_x_full = s1_num_x_r * $signed({1'b0, scale_x});
  assign prod_y_full = s1_num_y_r * $signed({1'b0, scale_y});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_prod_x_r <= prod_x_full[pdvm_pkg::PROD_W-1:0];
      s2_prod_y_r <= prod_y_full[pdvm_pkg::PROD_W-1:0];
      s2_wabs_r   <= s1_wabs_r;
      s2_negw_r   <= s1_negw_r;
      s2_tag_r    <= s1_tag_r;
    end
  end

  assign an_x = s2_prod_x_r[pdvm_pkg::PROD_W-1] ? (~s2_prod_x_r + 1'b1) : s2_prod_x_r;
  assign an_y = s2_prod_y_r[pdvm_pkg::PROD_W-1] ? (~s2_prod_y_r + 1'b1) : s2_prod_y_r;

  // quotient of (2|n| + |d|) / (2|d|) with d = 2w gives round half away from zero
  always_comb begin
    item_nxt.rem_x = {an_x, 1'b0} + pdvm_pkg::MAG_W'({s2_wabs_r, 1'b0});
    item_nxt.rem_y = {an_y, 1'b0} + pdvm_pkg::MAG_W'({s2_wabs_r, 1'b0});
    item_nxt.den   = {s2_wabs_r, 2'b00};
    item_nxt.neg_x = s2_prod_x_r[pdvm_pkg::PROD_W-1] ^ s2_negw_r;
    item_nxt.neg_y = s2_prod_y_r[pdvm_pkg::PROD_W-1] ^ s2_negw_r;
    item_nxt.ovf_x = 1'b0;
    item_nxt.ovf_y = 1'b0;
    item_nxt.tag   = s2_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_item_r <= item_nxt;
    end
  end

  assign out_valid = s3_v_r;
  assign out_item  = s3_item_r;

endmodule

/* hdl/pdvm_div_step.sv */
module pdvm_div_step #(
  parameter int PIXEL_BITS = 16,
  parameter int BIT        = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  pdvm_pkg::div_item_t     in_item,
  input  logic [PIXEL_BITS-1:0]   in_qx,
  input  logic [PIXEL_BITS-1:0]   in_qy,
  output logic                    out_valid,
  input  logic                    out_ready,
  output pdvm_pkg::div_item_t     out_item,
  output logic [PIXEL_BITS-1:0]   out_qx,
  output logic [PIXEL_BITS-1:0]   out_qy
);

  localparam int CMP_W = pdvm_pkg::MAG_W + PIXEL_BITS;

  logic                  v_r;
  pdvm_pkg::div_item_t   item_r, item_nxt;
  logic [PIXEL_BITS-1:0] qx_r, qy_r, qx_nxt, qy_nxt;
  logic [CMP_W-1:0]      dsh, rx, ry, diff_x, diff_y;
  logic                  ge_x, ge_y;

  assign dsh    = CMP_W'(in_item.den) << BIT;
  assign rx     = CMP_W'(in_item.rem_x);
  assign ry     = CMP_W'(in_item.rem_y);
  assign ge_x   = rx >= dsh;
  assign ge_y   = ry >= dsh;
  assign diff_x = rx - dsh;
  assign diff_y = ry - dsh;

  generate
    if (BIT == PIXEL_BITS) begin : g_ovf
      // quotient would need more than PIXEL_BITS bits
      always_comb begin
        item_nxt       = in_item;
        item_nxt.ovf_x = ge_x;
        item_nxt.ovf_y = ge_y;
        qx_nxt         = in_qx;
        qy_nxt         = in_qy;
      end
    end else begin : g_bit
      always_comb begin
        item_nxt = in_item;
        qx_nxt   = in_qx;
        qy_nxt   = in_qy;
        if (ge_x) begin
          item_nxt.rem_x = diff_x[pdvm_pkg::MAG_W-1:0];
          qx_nxt[BIT]    = 1'b1;
        end
        if (ge_y) begin
          item_nxt.rem_y = diff_y[pdvm_pkg::MAG_W-1:0];
          qy_nxt[BIT]    = 1'b1;
        end
      end
    end
  endgenerate

  assign in_ready = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_item  = item_r;
  assign out_qx    = qx_r;
  assign out_qy    = qy_r;

endmodule

/* hdl/pdvm_back.sv */
module pdvm_back #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  pdvm_pkg::div_item_t                   in_item,
  input  logic [PIXEL_BITS-1:0]                 in_qx,
  input  logic [PIXEL_BITS-1:0]                 in_qy,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((2*PIXEL_BITS+7)/8)*8-1:0]     m_axis_tdata,
  output logic [1:0]                            m_axis_tuser,
  output logic                                  m_axis_tlast
);

  localparam int OUT_W = ((2*PIXEL_BITS+7)/8)*8;
  localparam logic [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
  localparam logic [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

  logic                  tvalid_r;
  logic [OUT_W-1:0]      tdata_r, tdata_nxt;
  logic [1:0]            tuser_r, tuser_nxt;
  logic                  tlast_r;
  logic                  sat_x, sat_y;
  logic [PIXEL_BITS-1:0] px, py;

  // negative side may reach one step further than the positive side
  always_comb begin
    if (in_item.neg_x) begin
      sat_x = in_item.ovf_x || (in_qx[PIXEL_BITS-1] && |in_qx[PIXEL_BITS-2:0]);
      px    = sat_x ? PIX_MIN : (~in_qx + 1'b1);
    end else begin
      sat_x = in_item.ovf_x || in_qx[PIXEL_BITS-1];
      px    = sat_x ? PIX_MAX : in_qx;
    end
    if (in_item.neg_y) begin
      sat_y = in_item.ovf_y || (in_qy[PIXEL_BITS-1] && |in_qy[PIXEL_BITS-2:0]);
      py    = sat_y ? PIX_MIN : (~in_qy + 1'b1);
    end else begin
      sat_y = in_item.ovf_y || in_qy[PIXEL_BITS-1];
      py    = sat_y ? PIX_MAX : in_qy;
    end
  end

  always_comb begin
    tuser_nxt = '0;
    if (in_item.tag.w_zero) begin
      tdata_nxt                    = '0;
      tuser_nxt[pdvm_pkg::USER_WZ] = 1'b1;
    end else begin
      tdata_nxt                     = OUT_W'({py, px});
      tuser_nxt[pdvm_pkg::USER_SAT] = sat_x || sat_y;
    end
  end

  assign in_ready = !tvalid_r || m_axis_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvalid_r <= 1'b0;
    end else if (in_ready) begin
      tvalid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tdata_r <= tdata_nxt;
      tuser_r <= tuser_nxt;
      tlast_r <= in_item.tag.last;
    end
  end

  assign m_axis_tvalid = tvalid_r;
  assign m_axis_tdata  = tdata_r;
  assign m_axis_tuser  = tuser_r;
  assign m_axis_tlast  = tlast_r;

endmodule

/* hdl/perspective_divide_viewport_map.sv */
// Perspective divide and viewport map for a stream of homogeneous points.
// in_ channel: one word per point, x, y and w as signed 32-bit codes in
// in_tdata and the last-point mark on in_tlast. out_ channel: one word per
// point, pixel column and row in out_tdata, saturated and w_zero flags in
// out_tuser, the last-point mark copied to out_tlast.
// cfg_ port sets viewport width (index 0) and height (index 1); write it
// only while no point is in flight.
// Throughput is one point per clock while out_tready stays high. A point
// passes PIXEL_BITS + 5 register stages (21 at the default): three front
// stages (offsets, scale multiply, magnitudes), PIXEL_BITS + 1 restoring
// divider stages (an overflow check, then one quotient bit per stage) and
// the output register, which drives out_tvalid.
// Every stage has its own valid bit and holds while the stage after it is
// full and stalled, so bubbles close up when out_tready drops; in_tready
// falls only once every stage holds a word.
// Reset clears all valid bits and loads width 640 and height 480.
`include "perspective_divide_viewport_map_macros.svh"

module perspective_divide_viewport_map #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wen,
  input  logic                               cfg_index,
  input  logic [14:0]                        cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [95:0]                        in_tdata,   // x_coord, y_coord, w_coord
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((2*PIXEL_BITS+7)/8)*8-1:0]  out_tdata,  // pixel_x, pixel_y, zero fill
  output logic [1:0]                         out_tuser,  // saturated, w_zero
  output logic                               out_tlast
);

  localparam int NSTG = PIXEL_BITS + 2;
  localparam logic [PIXEL_BITS-1:0] PIX_MAX = {1'b0, {(PIXEL_BITS-1){1'b1}}};
  localparam logic [PIXEL_BITS-1:0] PIX_MIN = {1'b1, {(PIXEL_BITS-1){1'b0}}};

  logic                  st_valid [NSTG];
  logic                  st_ready [NSTG];
  pdvm_pkg::div_item_t   st_item  [NSTG];
  logic [PIXEL_BITS-1:0] st_qx    [NSTG];
  logic [PIXEL_BITS-1:0] st_qy    [NSTG];

  pdvm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_x      (in_tdata[31:0]),
    .in_y      (in_tdata[63:32]),
    .in_w      (in_tdata[95:64]),
    .in_last   (in_tlast),
    .out_valid (st_valid[0]),
    .out_ready (st_ready[0]),
    .out_item  (st_item[0])
  );

  assign st_qx[0] = '0;
  assign st_qy[0] = '0;

  // stage j resolves quotient bit PIXEL_BITS - j, the first one checks overflow
  genvar j;
  generate
    for (j = 0; j <= PIXEL_BITS; j++) begin : g_div
      pdvm_div_step #(
        .PIXEL_BITS (PIXEL_BITS),
        .BIT        (PIXEL_BITS - j)
      ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (st_valid[j]),
        .in_ready  (st_ready[j]),
        .in_item   (st_item[j]),
        .in_qx     (st_qx[j]),
        .in_qy     (st_qy[j]),
        .out_valid (st_valid[j+1]),
        .out_ready (st_ready[j+1]),
        .out_item  (st_item[j+1]),
        .out_qx    (st_qx[j+1]),
        .out_qy    (st_qy[j+1])
      );
    end
  endgenerate

  pdvm_back #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (st_valid[NSTG-1]),
    .in_ready      (st_ready[NSTG-1]),
    .in_item       (st_item[NSTG-1]),
    .in_qx         (st_qx[NSTG-1]),
    .in_qy         (st_qy[NSTG-1]),
    .m_axis_tvalid (out_tvalid),
    .m_axis_tready (out_tready),
    .m_axis_tdata  (out_tdata),
    .m_axis_tuser  (out_tuser),
    .m_axis_tlast  (out_tlast)
  );

  `PDVM_ASSERT_IMP(a_stall_only_when_full, !in_tready,
    out_tvalid && !out_tready, "input stalled while output free")
  `PDVM_ASSERT_IMP(a_wzero_clears, out_tvalid && out_tuser[pdvm_pkg::USER_WZ],
    (out_tdata == '0) && !out_tuser[pdvm_pkg::USER_SAT], "zero divisor word not cleared")
  `PDVM_ASSERT_IMP(a_sat_at_limit, out_tvalid && out_tuser[pdvm_pkg::USER_SAT],
    (out_tdata[PIXEL_BITS-1:0] == PIX_MAX) || (out_tdata[PIXEL_BITS-1:0] == PIX_MIN) ||
    (out_tdata[2*PIXEL_BITS-1:PIXEL_BITS] == PIX_MAX) ||
    (out_tdata[2*PIXEL_BITS-1:PIXEL_BITS] == PIX_MIN), "saturated word not at a limit")
  `PDVM_ASSERT_AFTER_RST(a_reset_empty, !out_tvalid && in_tready,
    "pipeline not empty after reset")

endmodule

/* dv/perspective_divide_viewport_map_tb.sv */
module perspective_divide_viewport_map_tb;

  localparam int TIMEOUT_CYCLES = 400000;
  localparam int DRAIN_CYCLES   = 40;    // more than the 21-stage pipe

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wen;
  logic        cfg_index;
  logic [14:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // x_coord, y_coord, w_coord
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // pixel_x, pixel_y
  logic [1:0]  out_tuser;  // saturated, w_zero
  logic        out_tlast;

  perspective_divide_viewport_map dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #10 clk = ~clk;

  class pixel_scoreboard;
    typedef struct {
      logic [15:0] px;
      logic [15:0] py;
      logic        sat;
      logic        wz;
      logic        last;
    } pixel_t;

    pixel_t      pending_pixels[$];
    int unsigned vp_width  = 640;
    int unsigned vp_height = 480;
    int          errors    = 0;
    int          points    = 0;
    int          checked   = 0;
    int          clamped   = 0;
    int          zero_w    = 0;

    function void set_size(pdvm_pkg::cfg_reg_t idx, logic [14:0] val);
      if (idx == pdvm_pkg::CFG_WIDTH) vp_width = val;
      else vp_height = val;
    endfunction

    // round(num * (size - 1) / (2 w)) half away from zero, clamped to 16 bits
    function automatic void map_axis(input longint num, input longint w,
                                     input int unsigned size,
                                     output logic [15:0] pix, output bit clamp);
      longint scale, n, d;
      longint unsigned an, ad, mag;
      scale = (size == 0) ? 0 : longint'(size) - 1;
      n = num * scale;
      d = 2 * w;
      if (d < 0) begin
        d = -d;
        n = -n;
      end
      an = (n < 0) ? -n : n;
      ad = d;
      mag = (64'd2 * an + ad) / (64'd2 * ad);
      clamp = 1'b0;
      if (n < 0) begin
        if (mag > 64'd32768) begin
          clamp = 1'b1;
          pix = 16'h8000;
        end else begin
          pix = 16'(-longint'(mag));
        end
      end else if (mag > 64'd32767) begin
        clamp = 1'b1;
        pix = 16'h7fff;
      end else begin
        pix = 16'(mag);
      end
    endfunction

    function void note_point(int x, int y, int w, bit last);
      pixel_t e;
      bit cx, cy;
      e.px = '0;
      e.py = '0;
      e.sat = 1'b0;
      e.wz = (w == 0);
      e.last = last;
      if (w != 0) begin
        map_axis(longint'(x) + w, longint'(w), vp_width, e.px, cx);
        map_axis(longint'(w) - y, longint'(w), vp_height, e.py, cy);
        e.sat = cx | cy;
      end
      if (e.sat) clamped++;
      if (e.wz) zero_w++;
      pending_pixels.push_back(e);
      points++;
    endfunction

    function void check_word(logic [31:0] data, logic [1:0] user, logic last);
      pixel_t e;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected word data=%h user=%b last=%b", $time, data, user, last);
        return;
      end
      e = pending_pixels.pop_front();
      checked++;
      if (data[15:0] !== e.px || data[31:16] !== e.py ||
          user[pdvm_pkg::USER_SAT] !== e.sat ||
          user[pdvm_pkg::USER_WZ] !== e.wz || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("%0t: word %0d mismatch: px %h/%h py %h/%h sat %b/%b wz %b/%b last %b/%b",
                   $time, checked, e.px, data[15:0], e.py, data[31:16], e.sat,
                   user[pdvm_pkg::USER_SAT], e.wz, user[pdvm_pkg::USER_WZ], e.last, last);
      end
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  pixel_scoreboard sb;
  bit  idle_on = 1'b1;
  int  stall_left = 0;
  int  cycle_count = 0;
  int  settings_used = 1;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("timeout with %0d words outstanding", sb.pending());
      $display("FAIL perspective_divide_viewport_map");
      $finish;
    end
  end

  // receiver backpressure in bursts of random length while idle_on is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser, out_tlast);
  end

  task automatic send_point(int x, int y, int w, bit last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {w, y, x};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_point(x, y, w, last);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic set_viewport(logic [14:0] width, logic [14:0] height);
    cfg_wen <= 1'b1;
    cfg_index <= pdvm_pkg::CFG_WIDTH;
    cfg_wdata <= width;
    @(posedge clk);
    cfg_index <= pdvm_pkg::CFG_HEIGHT;
    cfg_wdata <= height;
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.set_size(pdvm_pkg::CFG_WIDTH, width);
    sb.set_size(pdvm_pkg::CFG_HEIGHT, height);
    settings_used++;
  endtask

  // coordinate near w so that most points land on or near the screen
  function automatic int near_w(int w);
    longint v;
    v = (longint'(w) * (int'($urandom_range(0, 12288)) - 6144)) / 4096;
    v += int'($urandom_range(0, 2)) - 1;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return int'(v);
  endfunction

  task automatic send_random(int count);
    int x, y, w, mode;
    bit last;
    repeat (count) begin
      mode = $urandom_range(0, 9);
      last = ($urandom_range(0, 7) == 0);
      if (mode < 2) begin
        x = $urandom;
        y = $urandom;
        w = $urandom;
      end else if (mode == 2) begin
        x = $urandom;
        y = $urandom;
        w = 0;
      end else begin
        w = $signed($urandom) >>> $urandom_range(0, 30);
        if (w == 0) w = 1;
        x = near_w(w);
        y = near_w(w);
      end
      send_point(x, y, w, last);
    end
  endtask

  task automatic send_directed();
    localparam int MAXI = 32'sh7fffffff;
    localparam int MINI = 32'sh80000000;
    send_point(0, 0, 65536, 1'b0);            // screen center, both halves round up
    send_point(12345, -777, 0, 1'b1);         // zero divisor
    send_point(0, 0, 0, 1'b0);
    send_point(MAXI, MINI, 1, 1'b0);          // clamp high on x, high on y
    send_point(MINI, MAXI, 1, 1'b1);          // clamp low on both
    send_point(MINI, MINI, MINI, 1'b0);       // x/w = 1, y/w = 1
    send_point(MAXI, MAXI, MAXI, 1'b0);
    send_point(1, -1, -1, 1'b0);              // negative divisor
    send_point(0, 0, -1, 1'b1);
    send_point(-65536, 65536, 65536, 1'b0);   // left and top edges
    send_point(MAXI, 0, MINI, 1'b0);
    send_point(MINI, MINI, MAXI, 1'b0);
    send_point(-131072, 131072, 65536, 1'b0); // exact negative half rounds away
    send_point(196608, -196608, 65536, 1'b0);
    send_point(-1, -1, 2, 1'b1);
    send_point(MAXI, MAXI, MINI, 1'b0);
    send_point(MINI, 0, MAXI, 1'b0);
    send_point(1, 1, MAXI, 1'b0);
    send_point(-1, 1, MINI, 1'b1);
    send_point(3, -5, 7, 1'b0);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_wen = 1'b0;
    cfg_index = pdvm_pkg::CFG_WIDTH;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_directed();
    send_random(300);
    wait_drained();

    set_viewport(15'd1, 15'd1);
    send_directed();
    send_random(180);
    wait_drained();

    set_viewport(15'd16384, 15'd16384);
    send_directed();
    send_random(230);
    wait_drained();

    // zero size behaves like one
    set_viewport(15'd0, 15'd0);
    send_random(150);
    wait_drained();

    set_viewport(15'd32767, 15'd32767);
    send_directed();
    send_random(180);
    wait_drained();

    repeat (3) begin
      set_viewport(15'($urandom_range(1, 16384)), 15'($urandom_range(1, 16384)));
      send_random(200);
      wait_drained();
    end

    // closing stretch at full rate on both sides
    idle_on = 1'b0;
    set_viewport(15'd1920, 15'd1080);
    send_directed();
    send_random(230);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d points over %0d viewport settings, %0d words checked",
             sb.points, settings_used, sb.checked);
    $display("%0d clamped, %0d zero divisor, %0d mismatches",
             sb.clamped, sb.zero_w, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS perspective_divide_viewport_map");
    end else begin
      $display("FAIL perspective_divide_viewport_map");
    end
    $finish;
  end

endmodule
